>>> hw/rtl/sba_pkg.sv
package sba_pkg;

  localparam int ADDR_W     = 32;
  localparam int CFG_DATA_W = 32;
  localparam int SLOT_LOG_W = 4;

  // opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_UNALIGNED = 2'd3;

  // configuration register indexes
  localparam logic REG_REGION_BASE    = 1'b0;
  localparam logic REG_SLOT_SIZE_LOG2 = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [ADDR_W-1:0] free_address;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] slot_address;
  } res_t;

endpackage

>>> hw/rtl/sba_ram.sv
module sba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hw/rtl/sba_word.sv
module sba_word #(
  parameter int WORD_BITS  = 64,
  parameter int PAGE_BYTES = 4096
) (
  input  logic [WORD_BITS-1:0]                 word,
  input  logic [sba_pkg::SLOT_LOG_W-1:0]       slot_size_log2,
  output logic [WORD_BITS-1:0]                 counted_mask,
  output logic                                 found,
  output logic [$clog2(WORD_BITS)-1:0]         low_idx,
  output logic [WORD_BITS-1:0]                 cleared
);

  localparam int BIT_W  = $clog2(WORD_BITS);
  localparam int PAGE_W = $clog2(PAGE_BYTES) + 1;

  logic [PAGE_W-1:0]    per_page;
  logic [WORD_BITS-1:0] avail;
  logic [WORD_BITS-1:0] lowest;

  assign per_page = PAGE_W'(PAGE_BYTES) >> slot_size_log2;

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      counted_mask[j] = PAGE_W'(j) < per_page;
    end
  end

  // isolate the lowest free counted slot
  assign avail   = word & counted_mask;
  assign lowest  = avail & (~avail + WORD_BITS'(1));
  assign found   = |avail;
  assign cleared = word & ~lowest;

  always_comb begin
    low_idx = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (lowest[j]) begin
        low_idx = low_idx | BIT_W'(j);
      end
    end
  end

endmodule

>>> hw/rtl/slab_bitmap_slot_allocator.sv
// Slot allocator over BLOCKS bitmap words of WORD_BITS slots, all free after
// reset. Raise start with a command word while busy is low; the command is
// taken at that edge and busy stays high until the result word has been shown
// on result for the single cycle in which done is high. The receiver cannot
// stall: sample result whenever done is high. The next command may be taken
// in the cycle after done. Each command walks the bitmap words block by block
// through the one RAM port: an allocate reads each word (AREAD, AEVAL) until
// one has a free slot or all are read, then forms the address (ASLOT); a free
// checks range and alignment (FCHECK), steps through the blocks until the slot
// falls in one (FWALK) and writes the word back (FWRITE), which a rejected free
// skips. No clearing pass is run after reset: per-block
// valid flags make an untouched word read as all free. Write region_base
// (index 0) and slot_size_log2 (index 1) only while the block is idle.
module slab_bitmap_slot_allocator #(
  parameter int WORD_BITS  = 64,
  parameter int BLOCKS     = 8,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  sba_pkg::cmd_t                       cmd,
  input  logic                                cfg_write,
  input  logic                                cfg_index,
  input  logic [sba_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                done,
  output sba_pkg::res_t                       result
);

  localparam int BIT_W = $clog2(WORD_BITS);
  localparam int BLK_W = BLOCKS > 1 ? $clog2(BLOCKS) : 1;
  localparam int TOTAL = BLOCKS * WORD_BITS;
  localparam int IDX_W = $clog2(TOTAL);
  localparam int AW    = sba_pkg::ADDR_W;

  typedef enum logic [7:0] {
    IDLE   = 8'b0000_0001,
    AREAD  = 8'b0000_0010,
    AEVAL  = 8'b0000_0100,
    ASLOT  = 8'b0000_1000,
    FCHECK = 8'b0001_0000,
    FWALK  = 8'b0010_0000,
    FWRITE = 8'b0100_0000,
    DONE   = 8'b1000_0000
  } state_t;

  state_t state;

  // configuration
  logic [AW-1:0]                  region_base;
  logic [sba_pkg::SLOT_LOG_W-1:0] slot_size_log2;

  // working registers
  logic [BLK_W-1:0]     blk;
  logic [IDX_W-1:0]     blk_base;
  logic [IDX_W-1:0]     slot_idx;
  logic [BIT_W-1:0]     bit_sel;
  logic [AW-1:0]        offset;
  logic                 range_err;
  logic                 misalign;
  logic [BLOCKS-1:0]    blk_valid;
  sba_pkg::res_t        res;

  // bitmap datapath
  logic [WORD_BITS-1:0] ram_q;
  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] counted_mask;
  logic [WORD_BITS-1:0] cleared;
  logic [WORD_BITS-1:0] wr_data;
  logic [BIT_W-1:0]     low_idx;
  logic                 found;
  logic                 wr_en;

  // free path helpers
  logic [AW-1:0]        idx_wide;
  logic [IDX_W-1:0]     rel;
  logic                 rel_hit;

  logic accept;

  assign accept = start && !busy;
  assign busy   = state != IDLE;
  assign done   = state == DONE;
  assign result = res;

  // a word never written since reset reads as all free
  assign word = blk_valid[blk] ? ram_q : '1;

  assign wr_en   = (state == AEVAL && found) || state == FWRITE;
  assign wr_data = state == FWRITE ? (word | (WORD_BITS'(1) << bit_sel)) : cleared;

  assign idx_wide = offset >> slot_size_log2;
  assign rel      = slot_idx - blk_base;
  assign rel_hit  = {1'b0, rel} < (IDX_W + 1)'(WORD_BITS);

  sba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (BLOCKS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (blk),
    .wr_data (wr_data),
    .rd_addr (blk),
    .rd_data (ram_q)
  );

  sba_word #(
    .WORD_BITS  (WORD_BITS),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_word (
    .word           (word),
    .slot_size_log2 (slot_size_log2),
    .counted_mask   (counted_mask),
    .found          (found),
    .low_idx        (low_idx),
    .cleared        (cleared)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      region_base    <= '0;
      slot_size_log2 <= sba_pkg::SLOT_LOG_W'(4);
    end else if (cfg_write) begin
      case (cfg_index)
        sba_pkg::REG_REGION_BASE:    region_base    <= cfg_data;
        sba_pkg::REG_SLOT_SIZE_LOG2: slot_size_log2 <= cfg_data[sba_pkg::SLOT_LOG_W-1:0];
        default: ;
      endcase
    end
  end

  // mark a block's word valid once it has been written back
  always_ff @(posedge clk) begin
    if (rst) begin
      blk_valid <= '0;
    end else if (wr_en) begin
      blk_valid[blk] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      blk   <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (accept) begin
            res.status       <= sba_pkg::ST_OK;
            res.slot_address <= '0;
            offset           <= cmd.free_address - region_base;
            blk              <= '0;
            blk_base         <= '0;
            state            <= cmd.opcode == sba_pkg::OP_FREE ? FCHECK : AREAD;
          end
        end
        // read of the current block's word is in flight
        AREAD: begin
          state <= AEVAL;
        end
        AEVAL: begin
          if (found) begin
            slot_idx <= blk_base + IDX_W'(low_idx);
            state    <= ASLOT;
          end else if (blk == BLK_W'(BLOCKS - 1)) begin
            res.status <= sba_pkg::ST_FULL;
            state      <= DONE;
          end else begin
            blk      <= blk + BLK_W'(1);
            blk_base <= blk_base + IDX_W'(WORD_BITS);
            state    <= AREAD;
          end
        end
        ASLOT: begin
          res.slot_address <= region_base + (AW'(slot_idx) << slot_size_log2);
          state            <= DONE;
        end
        FCHECK: begin
          range_err <= idx_wide >= AW'(TOTAL);
          misalign  <= |(offset & ~({AW{1'b1}} << slot_size_log2));
          slot_idx  <= idx_wide[IDX_W-1:0];
          state     <= FWALK;
        end
        // reject a slot beyond the region, else step through the blocks until the slot index falls inside one
        FWALK: begin
          if (range_err) begin
            res.status <= sba_pkg::ST_RANGE;
            state      <= DONE;
          end else if (rel_hit) begin
            bit_sel <= rel[BIT_W-1:0];
            if (!counted_mask[rel[BIT_W-1:0]]) begin
              res.status <= sba_pkg::ST_RANGE;
              state      <= DONE;
            end else if (misalign) begin
              res.status <= sba_pkg::ST_UNALIGNED;
              state      <= DONE;
            end else begin
              state <= FWRITE;
            end
          end else begin
            blk      <= blk + BLK_W'(1);
            blk_base <= blk_base + IDX_W'(WORD_BITS);
          end
        end
        FWRITE: begin
          state <= DONE;
        end
        DONE: begin
          state <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/sba_checker.sv
module sba_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input sba_pkg::res_t result
);

  // a taken command holds the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after a command was taken");

  // results appear only while a command is in progress
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe without a command in progress");

  // one result word per command: strobe lasts one cycle
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // only a successful allocate carries an address
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status != sba_pkg::ST_OK |-> result.slot_address == '0)
    else $error("address present on a failed command");

endmodule

bind slab_bitmap_slot_allocator sba_checker u_sba_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
